/* hw/rtl/hsv_pkg.sv */
// Shared constants and types for the HSV to RGB pixel converter.
package hsv_pkg;

  // Hue fixed point: degrees with HUE_FRAC_BITS fraction bits
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W         = 15;
  localparam int CH_W          = 8;
  localparam int CH_MAX        = (1 << CH_W) - 1;

  // Integer degrees part of the hue
  localparam int U_W      = HUE_W - HUE_FRAC_BITS;
  localparam int SEXT_DEG = 60;
  // One 60-degree sector in hue units
  localparam int HUE_60   = SEXT_DEG << HUE_FRAC_BITS;
  // Ramp factor k runs 0..HUE_60
  localparam int K_W      = $clog2(HUE_60 + 1);

  localparam int SECT_W = 3;

  // Register stages from accept to result strobe
  localparam int PIPE_DEPTH = 7;

  // Hue sectors, named by the colors at their edges
  localparam logic [SECT_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SECT_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SECT_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SECT_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SECT_W-1:0] SEC_BLU_MAG = 3'd4;
  localparam logic [SECT_W-1:0] SEC_MAG_RED = 3'd5;

  // Hue front end to channel back end
  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [K_W-1:0]    k;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } hsv_mid_t;

endpackage

/* hw/rtl/hsv_hue.sv */
// Hue front end: sector index and ramp factor over three stages.
module hsv_hue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [hsv_pkg::HUE_W-1:0]  hue,
  input  logic [hsv_pkg::CH_W-1:0]   sat,
  input  logic [hsv_pkg::CH_W-1:0]   val,
  output logic                       out_valid,
  output hsv_pkg::hsv_mid_t          mid
);
  import hsv_pkg::*;

  // u / 60 by reciprocal; estimate is exact or one low
  localparam int RECIP_SH = 16;
  localparam int RECIP    = (1 << RECIP_SH) / SEXT_DEG;
  localparam int PROD_W   = RECIP_SH + U_W + 1;
  localparam int QU_MAX   = ((1 << U_W) - 1) / SEXT_DEG;
  localparam int QU_W     = (QU_MAX < 2) ? 1 : $clog2(QU_MAX + 1);
  localparam int RM_W     = $clog2(SEXT_DEG);
  localparam int R_W      = K_W + 1;
  localparam logic [HUE_W-1:0] FRAC_MASK = HUE_W'((1 << HUE_FRAC_BITS) - 1);
  localparam logic [R_W-1:0]   Q_R       = R_W'(HUE_60);
  localparam logic [R_W-1:0]   Q2_R      = R_W'(2 * HUE_60);

  // x mod 3: base-4 digits each weigh 1 mod 3
  function automatic logic [1:0] mod3(input logic [QU_W-1:0] x);
    logic [QU_W:0] xp;
    logic [4:0]    acc;
    logic [2:0]    s2;
    logic [2:0]    s3;
    xp  = {1'b0, x};
    acc = '0;
    for (int i = 0; i < QU_W; i += 2) begin
      acc = acc + 5'(xp[i +: 2]);
    end
    s2 = 3'(acc[1:0]) + 3'(acc[3:2]) + 3'(acc[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

  // stage A: reciprocal product
  logic              a_valid;
  logic [PROD_W-1:0] a_prod;
  logic [U_W-1:0]    a_u;
  logic [HUE_W-1:0]  a_frac;
  logic [CH_W-1:0]   a_sat;
  logic [CH_W-1:0]   a_val;

  // stage B: corrected quotient and remainder
  logic              b_valid;
  logic [QU_W-1:0]   b_quot;
  logic [RM_W-1:0]   b_rmod;
  logic [HUE_W-1:0]  b_frac;
  logic [CH_W-1:0]   b_sat;
  logic [CH_W-1:0]   b_val;

  logic [U_W-1:0]    u;
  logic [QU_W-1:0]   q0;
  logic [U_W-1:0]    rem0;

  logic              par;
  logic [1:0]        m3;
  logic [RM_W:0]     rm120;
  logic [R_W-1:0]    r;
  logic [K_W-1:0]    k;

  assign u = hue[HUE_W-1:HUE_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_prod <= PROD_W'(u) * PROD_W'(RECIP);
    a_u    <= u;
    a_frac <= hue & FRAC_MASK;
    a_sat  <= sat;
    a_val  <= val;
  end

  assign q0   = a_prod[RECIP_SH +: QU_W];
  assign rem0 = a_u - U_W'(int'(q0) * SEXT_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    if (int'(rem0) >= SEXT_DEG) begin
      b_quot <= q0 + QU_W'(1);
      b_rmod <= RM_W'(int'(rem0) - SEXT_DEG);
    end else begin
      b_quot <= q0;
      b_rmod <= RM_W'(rem0);
    end
    b_frac <= a_frac;
    b_sat  <= a_sat;
    b_val  <= a_val;
  end

  // quot mod 6 = 2*((quot/2) mod 3) + parity
  assign par   = b_quot[0];
  assign m3    = mod3(b_quot >> 1);
  // position inside the 120-degree period
  assign rm120 = {1'b0, b_rmod} + (par ? (RM_W + 1)'(SEXT_DEG) : '0);
  assign r     = (R_W'(rm120) << HUE_FRAC_BITS) | R_W'(b_frac);
  assign k     = (r >= Q_R) ? K_W'(Q2_R - r) : K_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b_valid;
    end
    mid.sector <= {m3, par};
    mid.k      <= k;
    mid.sat    <= b_sat;
    mid.val    <= b_val;
  end

endmodule

/* hw/rtl/hsv_chan.sv */
// Channel back end: x+m and m bytes with ceiling, sector placement.
module hsv_chan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  hsv_pkg::hsv_mid_t         mid,
  output logic                      out_valid,
  output logic [hsv_pkg::CH_W-1:0]  red,
  output logic [hsv_pkg::CH_W-1:0]  green,
  output logic [hsv_pkg::CH_W-1:0]  blue
);
  import hsv_pkg::*;

  // t = sat*k + (255-sat)*Q, at most 255*Q
  localparam int T_W   = $clog2(CH_MAX * HUE_60 + 1);
  localparam int W_W   = T_W + CH_W + 1;
  // x divisor after the 2^F part is taken off: 255*60
  localparam int DIV_X = CH_MAX * SEXT_DEG;
  localparam int Y_W   = $clog2(CH_MAX * DIV_X + DIV_X);
  localparam int RX_SH = 32;
  localparam longint RX = (longint'(1) << RX_SH) / DIV_X;
  localparam int XP_W  = RX_SH + CH_W + 1;
  // m = ceil(val*(255-sat)/255)
  localparam int DIV_M = CH_MAX;
  localparam int ZM_W  = 2 * CH_W;
  localparam int RM_SH = 24;
  localparam int RMC   = (1 << RM_SH) / DIV_M;
  localparam int MP_W  = RM_SH + CH_W + 1;
  localparam logic [W_W-1:0] FRAC_RND = W_W'((1 << HUE_FRAC_BITS) - 1);

  // stage D
  logic              d_valid;
  logic [T_W-1:0]    d_t;
  logic [ZM_W-1:0]   d_zm;
  logic [CH_W-1:0]   d_val;
  logic [SECT_W-1:0] d_sector;
  // stage E
  logic              e_valid;
  logic [Y_W-1:0]    e_y;
  logic [MP_W-1:0]   e_mp;
  logic [ZM_W-1:0]   e_zm;
  logic [CH_W-1:0]   e_val;
  logic [SECT_W-1:0] e_sector;
  // stage F
  logic              f_valid;
  logic [XP_W-1:0]   f_xp;
  logic [Y_W-1:0]    f_y;
  logic [CH_W-1:0]   f_m;
  logic [CH_W-1:0]   f_val;
  logic [SECT_W-1:0] f_sector;

  logic [CH_W-1:0]   inv_sat;
  logic [W_W-1:0]    w;
  logic [CH_W-1:0]   qm;
  logic [ZM_W-1:0]   remm;
  logic [CH_W-1:0]   qx;
  logic [Y_W-1:0]    remx;
  logic [CH_W-1:0]   chan_x;

  assign inv_sat = CH_W'(CH_MAX) - mid.sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= in_valid;
    end
    d_t      <= T_W'(mid.sat) * T_W'(mid.k) + T_W'(inv_sat) * T_W'(HUE_60);
    d_zm     <= ZM_W'(mid.val) * ZM_W'(inv_sat) + ZM_W'(DIV_M - 1);
    d_val    <= mid.val;
    d_sector <= mid.sector;
  end

  assign w = W_W'(d_val) * W_W'(d_t);

  // nested ceiling: first by 2^F, then by 255*60 (bias added here)
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
    e_y      <= Y_W'((w + FRAC_RND) >> HUE_FRAC_BITS) + Y_W'(DIV_X - 1);
    e_mp     <= MP_W'(d_zm) * MP_W'(RMC);
    e_zm     <= d_zm;
    e_val    <= d_val;
    e_sector <= d_sector;
  end

  // reciprocal estimates are exact or one low
  assign qm   = e_mp[RM_SH +: CH_W];
  assign remm = e_zm - ZM_W'(int'(qm) * DIV_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
    f_xp     <= XP_W'(e_y) * XP_W'(RX);
    f_y      <= e_y;
    f_m      <= (remm >= ZM_W'(DIV_M)) ? qm + CH_W'(1) : qm;
    f_val    <= e_val;
    f_sector <= e_sector;
  end

  assign qx     = f_xp[RX_SH +: CH_W];
  assign remx   = f_y - Y_W'(int'(qx) * DIV_X);
  assign chan_x = (remx >= Y_W'(DIV_X)) ? qx + CH_W'(1) : qx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= f_valid;
    end
    unique case (f_sector)
      SEC_RED_YEL: begin
        red <= f_val;  green <= chan_x; blue <= f_m;
      end
      SEC_YEL_GRN: begin
        red <= chan_x; green <= f_val;  blue <= f_m;
      end
      SEC_GRN_CYN: begin
        red <= f_m;    green <= f_val;  blue <= chan_x;
      end
      SEC_CYN_BLU: begin
        red <= f_m;    green <= chan_x; blue <= f_val;
      end
      SEC_BLU_MAG: begin
        red <= chan_x; green <= f_m;    blue <= f_val;
      end
      default: begin
        // SEC_MAG_RED
        red <= f_val;  green <= f_m;    blue <= chan_x;
      end
    endcase
  end

endmodule

/* hw/rtl/hsv_to_rgb_pixel.sv */
// Top level of the HSV to 8-bit RGB pixel converter.
// Converts one HSV pixel per clock into 8-bit RGB. An item is taken at each
// rising edge where start is high and busy is low; busy is only high while
// rst is held, so after reset a new pixel may be issued every cycle. Each
// result appears on red/green/blue for exactly one cycle with done high.
// Results appear in issue order, with done registered alongside the bytes.
// There is no output stall: the receiver must take every done cycle. The
// pipeline has seven register stages: three in the hue front end
// (reciprocal divide by 60, remainder correction, sector and ramp factor)
// and four in the channel back end (chroma products, value product,
// reciprocal divide by 255*60, ceiling correction and sector placement).
// Hue is degrees with HUE_FRAC_BITS fraction bits; hue at or above 360
// wraps. Each channel is rounded up, and the largest channel always equals
// brightness.
module hsv_to_rgb_pixel (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [hsv_pkg::HUE_W-1:0] hue,
  input  logic [hsv_pkg::CH_W-1:0]  saturation,
  input  logic [hsv_pkg::CH_W-1:0]  brightness,
  output logic                      done,
  output logic [hsv_pkg::CH_W-1:0]  red,
  output logic [hsv_pkg::CH_W-1:0]  green,
  output logic [hsv_pkg::CH_W-1:0]  blue
);
  import hsv_pkg::*;

  logic     accept;
  logic     mid_valid;
  hsv_mid_t mid;

  // Pipeline never backs up; only reset holds off new items.
  assign busy   = rst;
  assign accept = start && !busy;

  // Sector and ramp factor k = Q - |hue mod 2Q - Q|
  hsv_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .hue       (hue),
    .sat       (saturation),
    .val       (brightness),
    .out_valid (mid_valid),
    .mid       (mid)
  );

  // Channel bytes: max = brightness, min and middle by exact ceilings
  hsv_chan u_chan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .mid       (mid),
    .out_valid (done),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

/* hw/rtl/hsv_chk.sv */
// Port-level checker for the pixel converter, bound to the top level.
module hsv_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [hsv_pkg::CH_W-1:0]  saturation,
  input logic [hsv_pkg::CH_W-1:0]  brightness,
  input logic                      done,
  input logic [hsv_pkg::CH_W-1:0]  red,
  input logic [hsv_pkg::CH_W-1:0]  green,
  input logic [hsv_pkg::CH_W-1:0]  blue
);
  import hsv_pkg::*;

  // every item comes out after the fixed latency
  a_lat_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_DEPTH done)
    else $error("accepted item gave no result");

  // no result without an item
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##PIPE_DEPTH !done)
    else $error("result with no item");

  // one channel always carries the value
  a_max_val: assert property (@(posedge clk) disable iff (rst)
    done |-> (red == $past(brightness, PIPE_DEPTH)) ||
             (green == $past(brightness, PIPE_DEPTH)) ||
             (blue == $past(brightness, PIPE_DEPTH)))
    else $error("no channel equals brightness");

  // zero saturation gives gray
  a_gray: assert property (@(posedge clk) disable iff (rst)
    done && ($past(saturation, PIPE_DEPTH) == '0) |-> (red == green) && (green == blue))
    else $error("unsaturated pixel not gray");

endmodule

bind hsv_to_rgb_pixel hsv_chk u_hsv_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .saturation (saturation),
  .brightness (brightness),
  .done       (done),
  .red        (red),
  .green      (green),
  .blue       (blue)
);
